>>> sv/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg: shared constants and types of the separable box blur
// Frame limits, derived widths, register and command codes, and the control
// bundles that pass between the sequencer, the channel lanes and the output.
// ----------------------------------------------------------------------------
package sbb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_WINDOW = 64;
  localparam int RING_ROWS  = MAX_WINDOW + 2;
  localparam int LANES      = 4;

  localparam int CFG_W    = 12;
  localparam int WIN_CFG  = 7;
  localparam int IDX_W    = 2;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WD_W     = $clog2(MAX_WIDTH + 1);
  localparam int HD_W     = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W    = HD_W;
  localparam int N_W      = $clog2(MAX_WINDOW + 1);
  localparam int TAP_W    = $clog2(MAX_WINDOW);
  localparam int RING_W   = $clog2(RING_ROWS);
  localparam int LS_AW    = RING_W + COL_W;
  localparam int LS_DEPTH = RING_ROWS * (1 << COL_W);
  localparam int SUM_W    = $clog2(MAX_WINDOW * 255 + 1);
  localparam int DCNT_W   = $clog2(SUM_W);
  localparam int CNT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int KW       = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic             rw_we;
    logic [COL_W-1:0] rw_waddr;
    logic [COL_W-1:0] rw_raddr;
    logic             ls_we;
    logic [LS_AW-1:0] ls_waddr;
    logic [LS_AW-1:0] ls_raddr;
    logic             acc_clr;
    logic             acc_en;
    logic             acc_sel;
    logic             div_start;
    logic             div_step;
    logic [N_W-1:0]   divisor;
  } sbb_lane_ctl_t;

  typedef struct packed {
    logic load;
    logic frame_end;
  } sbb_out_ctl_t;

endpackage

>>> sv/sbb_ram.sv
// ----------------------------------------------------------------------------
// sbb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sbb_lane.sv
// ----------------------------------------------------------------------------
// sbb_lane: one colour channel of the blur
// Holds the channel's row buffer and line store, sums the taps the sequencer
// reads, and divides the sum by the window length with round half to even.
// ----------------------------------------------------------------------------
module sbb_lane (
  input  logic                   clk,
  input  sbb_pkg::sbb_lane_ctl_t ctl,
  input  logic [7:0]             px,
  output logic [7:0]             res
);
  import sbb_pkg::*;

  logic [7:0]       rw_q;
  logic [7:0]       ls_q;
  logic [SUM_W-1:0] acc_r;
  logic [N_W-1:0]   rem_r;
  logic [SUM_W-1:0] quo_r;
  logic [N_W:0]     trial;
  logic [N_W:0]     dv;
  logic [N_W:0]     twice;
  logic             up;
  logic [SUM_W:0]   qr;

  sbb_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_row (
    .clk   (clk),
    .we    (ctl.rw_we),
    .waddr (ctl.rw_waddr),
    .wdata (px),
    .raddr (ctl.rw_raddr),
    .rdata (rw_q)
  );

  sbb_ram #(.WIDTH(8), .DEPTH(LS_DEPTH)) u_line (
    .clk   (clk),
    .we    (ctl.ls_we),
    .waddr (ctl.ls_waddr),
    .wdata (res),
    .raddr (ctl.ls_raddr),
    .rdata (ls_q)
  );

  assign dv    = {1'b0, ctl.divisor};
  assign trial = {rem_r, quo_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + SUM_W'(ctl.acc_sel ? ls_q : rw_q);
    end
    // restoring division, one quotient bit a cycle
    if (ctl.div_start) begin
      rem_r <= '0;
      quo_r <= acc_r;
    end else if (ctl.div_step) begin
      if (trial >= dv) begin
        rem_r <= N_W'(trial - dv);
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= N_W'(trial);
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign twice = {rem_r, 1'b0};
  assign up    = (twice > dv) || ((twice == dv) && quo_r[0]);
  assign qr    = {1'b0, quo_r} + (SUM_W + 1)'(up);
  assign res   = (qr > (SUM_W + 1)'(255)) ? 8'hFF : qr[7:0];

endmodule

>>> sv/sbb_ctrl.sv
// ----------------------------------------------------------------------------
// sbb_ctrl: frame sequencer of the blur
// Keeps the configuration, the raster counters and the ring row pointers, and
// steps the lanes through tap reads, division and line store writes.
// ----------------------------------------------------------------------------
module sbb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_command,
  output logic                        in_stall,
  input  logic                        cfg_we,
  input  logic [sbb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sbb_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        out_free,
  output sbb_pkg::sbb_lane_ctl_t      lane_ctl,
  output sbb_pkg::sbb_out_ctl_t       out_ctl
);
  import sbb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_LAST, ST_LOAD, ST_DIV, ST_HWRITE, ST_COUNT, ST_OUT
  } state_t;

  state_t              state_r;
  logic                vert_r;
  logic [WD_W-1:0]     w_r;
  logic [HD_W-1:0]     h_r;
  logic [N_W-1:0]      n_r;
  logic [CNT_W-1:0]    lag_r;
  logic [CNT_W-1:0]    total_r;
  logic [COL_W-1:0]    in_col_r;
  logic [RING_W-1:0]   in_ring_r;
  logic [CNT_W-1:0]    in_count_r;
  logic                done_r;
  logic [COL_W-1:0]    out_col_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [RING_W-1:0]   out_ring_r;
  logic [CNT_W-1:0]    out_count_r;
  logic [COL_W-1:0]    col_r;
  logic [COL_W-1:0]    hi_r;
  logic [TAP_W-1:0]    tap_r;
  logic signed [KW-1:0] k_r;
  logic [RING_W-1:0]   vring_r;
  logic                acc_vld_r;
  logic [DCNT_W-1:0]   dcnt_r;

  logic [N_W-1:0]        a;
  logic [N_W-1:0]        half;
  logic [WD_W-1:0]       w_m1;
  logic [HD_W-1:0]       h_m1;
  logic [N_W+WD_W-1:0]   aw;
  logic [WD_W+HD_W-1:0]  wh;
  logic                  accept;
  logic                  has_job;
  logic                  last_col;
  logic [COL_W-1:0]      h_col0;
  logic [COL_W-1:0]      h_hi0;
  logic signed [KW-1:0]  h_k0;
  logic signed [KW-1:0]  v_k0;
  logic signed [KW-1:0]  v_diff;
  logic [RING_W-1:0]     v_ring0;
  logic signed [KW-1:0]  k_nxt;
  logic [RING_W-1:0]     vring_nxt;
  logic [COL_W-1:0]      h_addr;
  logic [CNT_W-1:0]      in_cnt1;
  logic [CNT_W-1:0]      out_cnt1;
  logic                  emit;
  logic                  cfg_hit;

  function automatic logic [WD_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return WD_W'(1);
    end else if (v > CFG_W'(MAX_WIDTH)) begin
      return WD_W'(MAX_WIDTH);
    end
    return WD_W'(v);
  endfunction

  function automatic logic [HD_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return HD_W'(1);
    end else if (v > CFG_W'(MAX_HEIGHT)) begin
      return HD_W'(MAX_HEIGHT);
    end
    return HD_W'(v);
  endfunction

  function automatic logic [N_W-1:0] clamp_n(input logic [WIN_CFG-1:0] v);
    if (v == '0) begin
      return N_W'(1);
    end else if (v > WIN_CFG'(MAX_WINDOW)) begin
      return N_W'(MAX_WINDOW);
    end
    return N_W'(v);
  endfunction

  assign a    = (n_r - N_W'(1)) >> 1;
  assign half = n_r >> 1;
  assign w_m1 = w_r - WD_W'(1);
  assign h_m1 = h_r - HD_W'(1);
  assign aw   = a * w_r;
  assign wh   = w_r * h_r;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  // columns whose horizontal window closes with this pixel
  assign last_col = (WD_W'(in_col_r) == w_m1);
  assign has_job  = (in_col_r >= COL_W'(a)) || last_col;
  assign h_col0   = (in_col_r >= COL_W'(a)) ? (in_col_r - COL_W'(a)) : '0;
  assign h_hi0    = last_col ? COL_W'(w_m1) : (in_col_r - COL_W'(a));
  assign h_k0     = $signed(KW'(h_col0)) - $signed(KW'(half));

  // first vertical tap and its ring row
  assign v_k0    = $signed(KW'(out_row_r)) - $signed(KW'(half));
  assign v_diff  = $signed(KW'(out_ring_r)) - $signed(KW'(half));
  assign v_ring0 = (v_k0 < 0) ? '0 :
                   ((v_diff < 0) ? RING_W'(v_diff + RING_ROWS) : RING_W'(v_diff));

  // ring row follows the clamped row index: pinned at the top and bottom edges
  assign k_nxt = k_r + KW'(1);
  always_comb begin
    if (k_nxt <= 0) begin
      vring_nxt = '0;
    end else if (k_nxt > $signed(KW'(h_m1))) begin
      vring_nxt = vring_r;
    end else if (vring_r == RING_W'(RING_ROWS - 1)) begin
      vring_nxt = '0;
    end else begin
      vring_nxt = vring_r + RING_W'(1);
    end
  end

  always_comb begin
    if (k_r < 0) begin
      h_addr = '0;
    end else if (k_r > $signed(KW'(w_m1))) begin
      h_addr = COL_W'(w_m1);
    end else begin
      h_addr = COL_W'(k_r);
    end
  end

  assign in_cnt1  = in_count_r + CNT_W'(1);
  assign out_cnt1 = out_count_r + CNT_W'(1);
  assign emit     = ({1'b0, in_cnt1} > ({1'b0, lag_r} + {1'b0, out_count_r}));
  assign cfg_hit  = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT) ||
                               (cfg_index == REG_WINDOW));

  always_comb begin
    lane_ctl.rw_we     = accept && (in_command == CMD_PIXEL) && !done_r;
    lane_ctl.rw_waddr  = in_col_r;
    lane_ctl.rw_raddr  = h_addr;
    lane_ctl.ls_we     = (state_r == ST_HWRITE);
    lane_ctl.ls_waddr  = {in_ring_r, col_r};
    lane_ctl.ls_raddr  = {vring_r, out_col_r};
    lane_ctl.acc_clr   = (state_r == ST_READ) && (tap_r == '0);
    lane_ctl.acc_en    = acc_vld_r;
    lane_ctl.acc_sel   = vert_r;
    lane_ctl.div_start = (state_r == ST_LOAD);
    lane_ctl.div_step  = (state_r == ST_DIV);
    lane_ctl.divisor   = n_r;
    out_ctl.load       = (state_r == ST_OUT) && out_free;
    out_ctl.frame_end  = (out_cnt1 >= total_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vert_r      <= 1'b0;
      w_r         <= WD_W'(1);
      h_r         <= HD_W'(1);
      n_r         <= N_W'(1);
      lag_r       <= '0;
      total_r     <= CNT_W'(1);
      in_col_r    <= '0;
      in_ring_r   <= '0;
      in_count_r  <= '0;
      done_r      <= 1'b0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_ring_r  <= '0;
      out_count_r <= '0;
      col_r       <= '0;
      hi_r        <= '0;
      tap_r       <= '0;
      k_r         <= '0;
      vring_r     <= '0;
      acc_vld_r   <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      lag_r     <= CNT_W'(aw) + CNT_W'(a);
      total_r   <= CNT_W'(wh);
      acc_vld_r <= (state_r == ST_READ);

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_command == CMD_PIXEL) begin
              if (!done_r) begin
                vert_r <= 1'b0;
                if (has_job) begin
                  col_r   <= h_col0;
                  hi_r    <= h_hi0;
                  tap_r   <= '0;
                  k_r     <= h_k0;
                  state_r <= ST_READ;
                end else begin
                  state_r <= ST_COUNT;
                end
              end
            end else if (done_r && (out_count_r < total_r)) begin
              vert_r  <= 1'b1;
              tap_r   <= '0;
              k_r     <= v_k0;
              vring_r <= v_ring0;
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          tap_r   <= tap_r + TAP_W'(1);
          k_r     <= k_nxt;
          vring_r <= vring_nxt;
          if (N_W'(tap_r) == (n_r - N_W'(1))) begin
            state_r <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          dcnt_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(SUM_W - 1)) begin
            state_r <= vert_r ? ST_OUT : ST_HWRITE;
          end
        end
        ST_HWRITE: begin
          if (col_r == hi_r) begin
            state_r <= ST_COUNT;
          end else begin
            col_r   <= col_r + COL_W'(1);
            tap_r   <= '0;
            k_r     <= $signed(KW'(col_r)) + KW'(1) - $signed(KW'(half));
            state_r <= ST_READ;
          end
        end
        ST_COUNT: begin
          in_count_r <= in_cnt1;
          if (last_col) begin
            in_col_r  <= '0;
            in_ring_r <= (in_ring_r == RING_W'(RING_ROWS - 1)) ? '0 :
                         in_ring_r + RING_W'(1);
          end else begin
            in_col_r <= in_col_r + COL_W'(1);
          end
          if (in_cnt1 >= total_r) begin
            done_r <= 1'b1;
          end
          if (emit) begin
            vert_r  <= 1'b1;
            tap_r   <= '0;
            k_r     <= v_k0;
            vring_r <= v_ring0;
            state_r <= ST_READ;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_r     <= ST_IDLE;
            out_count_r <= out_cnt1;
            if (WD_W'(out_col_r) == w_m1) begin
              out_col_r  <= '0;
              out_row_r  <= out_row_r + ROW_W'(1);
              out_ring_r <= (out_ring_r == RING_W'(RING_ROWS - 1)) ? '0 :
                            out_ring_r + RING_W'(1);
            end else begin
              out_col_r <= out_col_r + COL_W'(1);
            end
            if (out_cnt1 >= total_r) begin
              in_col_r    <= '0;
              in_ring_r   <= '0;
              in_count_r  <= '0;
              done_r      <= 1'b0;
              out_col_r   <= '0;
              out_row_r   <= '0;
              out_ring_r  <= '0;
              out_count_r <= '0;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // a register write restarts the frame
      if (cfg_hit) begin
        unique case (cfg_index)
          REG_WIDTH:  w_r <= clamp_w(cfg_data);
          REG_HEIGHT: h_r <= clamp_h(cfg_data);
          default:    n_r <= clamp_n(cfg_data[WIN_CFG-1:0]);
        endcase
        in_col_r    <= '0;
        in_ring_r   <= '0;
        in_count_r  <= '0;
        done_r      <= 1'b0;
        out_col_r   <= '0;
        out_row_r   <= '0;
        out_ring_r  <= '0;
        out_count_r <= '0;
      end
    end
  end

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (N_W'(tap_r) < n_r))
    else $error("tap counter ran past the window");

  a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_count_r <= in_count_r)
    else $error("more results than pixels taken");

  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ring_r < RING_W'(RING_ROWS)) && (vring_r < RING_W'(RING_ROWS)) &&
    (out_ring_r < RING_W'(RING_ROWS)))
    else $error("ring row pointer out of range");

  a_load_vertical: assert property (@(posedge clk) disable iff (!rst_n)
    out_ctl.load |-> vert_r)
    else $error("result loaded from a horizontal job");

endmodule

>>> sv/separable_box_blur_rgba8.sv
// ----------------------------------------------------------------------------
// separable_box_blur_rgba8: separable box blur of an RGBA8 raster stream
// Four channel lanes under one sequencer, merged into a registered result.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; results trail by a*W + a pixels, with
// a = (N-1)/2, and drain requests push out the tail once the frame is in.
// Each request is worked on alone. A horizontal or vertical box sum reads
// one tap a cycle from a lane memory, then a shared-per-lane restoring
// divider works out the quotient one bit at a time. A pixel request runs
// the box sum and division for its horizontal column, plus a vertical one
// for a result when one is due; the last pixel of a row also finishes the
// a columns at the right border. A drain request runs one vertical sum.
// The line store is not cleared after reset: every entry is written before
// it is read within a frame. The next request is taken while a result still
// waits in the output register. A register write restarts the frame.
// ----------------------------------------------------------------------------
module separable_box_blur_rgba8 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [7:0]                in_red_in,
  input  logic [7:0]                in_green_in,
  input  logic [7:0]                in_blue_in,
  input  logic [7:0]                in_alpha_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_red_out,
  output logic [7:0]                out_green_out,
  output logic [7:0]                out_blue_out,
  output logic [7:0]                out_alpha_out,
  output logic                      out_frame_end,
  input  logic                      cfg_we,
  input  logic [sbb_pkg::IDX_W-1:0] cfg_index,
  input  logic [sbb_pkg::CFG_W-1:0] cfg_data
);
  import sbb_pkg::*;

  sbb_lane_ctl_t lane_ctl;
  sbb_out_ctl_t  out_ctl;
  logic          out_free;
  logic          out_valid_r;
  logic [7:0]    lane_px  [LANES];
  logic [7:0]    lane_res [LANES];
  logic [7:0]    out_px_r [LANES];
  logic          out_fe_r;

  // output slot frees when empty or when its request is taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  sbb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_free   (out_free),
    .lane_ctl   (lane_ctl),
    .out_ctl    (out_ctl)
  );

  // lane order: red, green, blue, alpha
  assign lane_px[0] = in_red_in;
  assign lane_px[1] = in_green_in;
  assign lane_px[2] = in_blue_in;
  assign lane_px[3] = in_alpha_in;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sbb_lane u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .px  (lane_px[i]),
      .res (lane_res[i])
    );
  end

  // merge the lanes into the result register; hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      for (int i = 0; i < LANES; i++) begin
        out_px_r[i] <= lane_res[i];
      end
      out_fe_r <= out_ctl.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_px_r[0];
  assign out_green_out = out_px_r[1];
  assign out_blue_out  = out_px_r[2];
  assign out_alpha_out = out_px_r[3];
  assign out_frame_end = out_fe_r;

endmodule
